/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check sampled on the rising clock, off while reset is active
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication check sampled on the rising clock, off while reset is active
`define CHK_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

/* rtl/rrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rrt_pkg;

	// sizes
	localparam int TABLE_DEPTH   = 256;
	localparam int MAP_DEPTH     = 65536;
	localparam int REQUEST_LIMIT = 64;
	localparam int BLK_W         = 16;
	localparam int MAP_AW        = $clog2(MAP_DEPTH);
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

	// input kinds
	localparam logic [1:0] KIND_MARK    = 2'd0;
	localparam logic [1:0] KIND_REQUEST = 2'd1;
	localparam logic [1:0] KIND_FLUSH   = 2'd2;

	// result request types
	localparam logic [1:0] REQ_NONE    = 2'd0;
	localparam logic [1:0] REQ_RETX    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// request status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_RCVD = 2'd1;
	localparam logic [1:0] STAT_DUP  = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RESP,
		S_REQ_LOOK,
		S_REQ_DONE,
		S_FL_START,
		S_FL_READ,
		S_FL_FILT,
		S_FL_END,
		S_FL_EMIT,
		S_RS_SHIFT,
		S_RS_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CMP,
		OP_INSERT,
		OP_SHIFT
	} cell_op_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		cell_op_t           op;
		logic [BLK_W-1:0]   blk;
		logic [BLK_W-1:0]   head;
		logic               keep;
		logic               sorted;
		logic [CNT_W-1:0]   count;
		logic [IDX_W-1:0]   wpos;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/rrt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* rtl/rrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrt_cell (
	input  wire logic                           clk,
	input  wire rrt_pkg::cell_ctrl_t            ctrl,
	input  wire logic [rrt_pkg::IDX_W-1:0]      idx,
	input  wire logic [rrt_pkg::BLK_W-1:0]      left_val,
	input  wire logic [rrt_pkg::BLK_W-1:0]      right_val,
	input  wire logic                           ins_at,
	input  wire logic                           shift_up,
	output logic      [rrt_pkg::BLK_W-1:0]      val,
	output logic                                ge,
	output logic                                eq
);

	logic [rrt_pkg::BLK_W-1:0] val_q;
	logic                      ge_q;
	logic                      eq_q;
	logic                      occupied;

	// entry holds a pending request when below the fill count
	assign occupied = {1'b0, idx} < ctrl.count;

	// compare flags for the insertion search
	always_ff @(posedge clk) begin
		if (ctrl.op == rrt_pkg::OP_CMP) begin
			ge_q <= !occupied || (ctrl.sorted && (val_q >= ctrl.blk));
			eq_q <= occupied && (val_q == ctrl.blk);
		end
	end

	// entry value: insert, shift down the row, or hold
	always_ff @(posedge clk) begin
		case (ctrl.op)
			rrt_pkg::OP_INSERT: begin
				if (ins_at) begin
					val_q <= ctrl.blk;
				end else if (shift_up) begin
					val_q <= left_val;
				end
			end
			rrt_pkg::OP_SHIFT: begin
				if (ctrl.keep && (idx == ctrl.wpos)) begin
					val_q <= ctrl.head;
				end else begin
					val_q <= right_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign val = val_q;
	assign ge  = ge_q;
	assign eq  = eq_q;

endmodule
`default_nettype wire

/* rtl/retransmit_request_tracker_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------------
// in        | in_valid / in_stall   | kind, block
// out       | out_valid / out_stall | req_code, req_block, restart_end, status,
//           |                       | pending_count, last
// cfg       | cfg_we                | cfg_wdata (sorted_mode)
//
// mark and unused kinds pass through one response state; a request does the map read and row compare, then the insert.
// flush: an empty table answers directly; else each pending entry is filtered (map read of the head
// entry, then a shift), then each retransmit result is emitted, or a single result when no entry is left.
// restart flush shifts the row to reach its last entry.
// after reset all 65536 entries of the received map are cleared with in_stall high.
// out_stall holds the result and freezes the sequence; input is taken while a final result waits.
module retransmit_request_tracker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       req_code,
	output logic [15:0]      req_block,
	output logic [15:0]      restart_end,
	output logic [1:0]       status,
	output logic [8:0]       pending_count,
	output logic             last
);

	localparam int BW = rrt_pkg::BLK_W;
	localparam int CW = rrt_pkg::CNT_W;
	localparam int IW = rrt_pkg::IDX_W;
	localparam int TD = rrt_pkg::TABLE_DEPTH;

	rrt_pkg::state_t state_q, state_d;

	logic                     sorted_q;
	logic [rrt_pkg::MAP_AW-1:0] clr_q;
	logic [1:0]               kind_q;
	logic [BW-1:0]            blk_q;
	logic [CW-1:0]            count_q, count_d;
	logic [CW-1:0]            n_q, n_d;
	logic [CW-1:0]            len_q, len_d;
	logic [CW-1:0]            e_q, e_d;
	logic [BW-1:0]            first_q, first_d;

	// output register
	logic                     out_valid_q;
	logic [1:0]               type_q;
	logic [BW-1:0]            rblk_q;
	logic [BW-1:0]            rend_q;
	logic [1:0]               stat_q;
	logic [CW-1:0]            pend_q;
	logic                     last_q;
	logic                     out_free;

	logic                     res_load;
	logic [1:0]               res_type;
	logic [BW-1:0]            res_blk;
	logic [BW-1:0]            res_end;
	logic [1:0]               res_status;
	logic [CW-1:0]            res_pending;
	logic                     res_last;

	// map memory
	logic                     ram_we;
	logic [rrt_pkg::MAP_AW-1:0] ram_waddr;
	logic                     ram_wdata;
	logic [rrt_pkg::MAP_AW-1:0] ram_raddr;
	logic                     ram_rdata;

	// cell row
	rrt_pkg::cell_ctrl_t      ctrl;
	logic [BW-1:0]            cell_val [TD];
	logic [TD-1:0]            ge_vec;
	logic [TD-1:0]            eq_vec;
	logic [TD-1:0]            below_incl;
	logic [TD-1:0]            pos_onehot;
	logic [TD-1:0]            above;
	logic                     do_insert;

	logic                     dup;
	logic                     full;
	logic [1:0]               req_status;
	logic                     keep;
	logic [CW-1:0]            len_m1;
	logic [CW-1:0]            cnt_m1;
	logic                     emit_last;
	logic                     in_stall_c;

	// result flags for the checks
	logic                     rs_out;
	logic                     flag_out;

	assign out_free = !out_valid_q || !out_stall;

	// first entry not below the block, and everything behind it
	assign below_incl = ge_vec ^ (ge_vec - TD'(1));
	assign pos_onehot = below_incl & ge_vec;
	assign above      = ~below_incl;

	assign dup        = sorted_q && |(pos_onehot & eq_vec);
	assign full       = count_q == CW'(TD);
	assign req_status = ram_rdata ? rrt_pkg::STAT_RCVD :
	                    dup       ? rrt_pkg::STAT_DUP  :
	                    full      ? rrt_pkg::STAT_FULL : rrt_pkg::STAT_OK;

	assign keep      = (cell_val[0] != '0) && !ram_rdata;
	assign len_m1    = len_q - CW'(1);
	assign cnt_m1    = count_q - CW'(1);
	assign emit_last = e_q == cnt_m1;

	rrt_ram #(
		.WIDTH (1),
		.DEPTH (rrt_pkg::MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// row of table cells, entry 0 at the head
	for (genvar i = 0; i < TD; i++) begin : g_cell
		logic [BW-1:0] left_v;
		logic [BW-1:0] right_v;
		if (i == 0) begin : g_head
			assign left_v = blk_q;
		end else begin : g_body
			assign left_v = cell_val[i-1];
		end
		if (i == TD - 1) begin : g_tail
			assign right_v = cell_val[i];
		end else begin : g_mid
			assign right_v = cell_val[i+1];
		end
		rrt_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (IW'(i)),
			.left_val  (left_v),
			.right_val (right_v),
			.ins_at    (pos_onehot[i] & do_insert),
			.shift_up  (above[i] & do_insert),
			.val       (cell_val[i]),
			.ge        (ge_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	// sequencer: next state, cell commands, map access, results
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		n_d         = n_q;
		len_d       = len_q;
		e_d         = e_q;
		first_d     = first_q;
		ctrl.op     = rrt_pkg::OP_HOLD;
		ctrl.blk    = blk_q;
		ctrl.head   = cell_val[0];
		ctrl.keep   = 1'b0;
		ctrl.sorted = sorted_q;
		ctrl.count  = count_q;
		ctrl.wpos   = len_m1[IW-1:0];
		do_insert   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = blk_q;
		ram_wdata   = 1'b1;
		ram_raddr   = blk_q;
		res_load    = 1'b0;
		res_type    = rrt_pkg::REQ_NONE;
		res_blk     = '0;
		res_end     = '0;
		res_status  = rrt_pkg::STAT_OK;
		res_pending = count_q;
		res_last    = 1'b1;
		in_stall_c  = 1'b1;
		case (state_q)
			rrt_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 1'b0;
				if (clr_q == '1) begin
					state_d = rrt_pkg::S_IDLE;
				end
			end
			rrt_pkg::S_IDLE: begin
				in_stall_c = 1'b0;
				if (in_valid) begin
					case (kind)
						rrt_pkg::KIND_REQUEST: state_d = rrt_pkg::S_REQ_LOOK;
						rrt_pkg::KIND_FLUSH:   state_d = rrt_pkg::S_FL_START;
						default:               state_d = rrt_pkg::S_RESP;
					endcase
				end
			end
			rrt_pkg::S_RESP: begin
				ram_we = kind_q == rrt_pkg::KIND_MARK;
				if (out_free) begin
					res_load = 1'b1;
					state_d  = rrt_pkg::S_IDLE;
				end
			end
			rrt_pkg::S_REQ_LOOK: begin
				ctrl.op = rrt_pkg::OP_CMP;
				state_d = rrt_pkg::S_REQ_DONE;
			end
			rrt_pkg::S_REQ_DONE: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_status = req_status;
					state_d    = rrt_pkg::S_IDLE;
					if (req_status == rrt_pkg::STAT_OK) begin
						ctrl.op     = rrt_pkg::OP_INSERT;
						do_insert   = 1'b1;
						count_d     = count_q + CW'(1);
						res_pending = count_q + CW'(1);
					end
				end
			end
			rrt_pkg::S_FL_START: begin
				if (count_q == '0) begin
					state_d = rrt_pkg::S_RESP;
				end else if (count_q > CW'(rrt_pkg::REQUEST_LIMIT)) begin
					first_d = cell_val[0];
					n_d     = cnt_m1;
					state_d = rrt_pkg::S_RS_SHIFT;
				end else begin
					n_d     = count_q;
					len_d   = count_q;
					state_d = rrt_pkg::S_FL_READ;
				end
			end
			rrt_pkg::S_FL_READ: begin
				ram_raddr = cell_val[0];
				state_d   = rrt_pkg::S_FL_FILT;
			end
			rrt_pkg::S_FL_FILT: begin
				ctrl.op   = rrt_pkg::OP_SHIFT;
				ctrl.keep = keep;
				n_d       = n_q - CW'(1);
				if (!keep) begin
					len_d = len_m1;
				end
				state_d = (n_q == CW'(1)) ? rrt_pkg::S_FL_END : rrt_pkg::S_FL_READ;
			end
			rrt_pkg::S_FL_END: begin
				count_d = len_q;
				e_d     = '0;
				state_d = (len_q == '0) ? rrt_pkg::S_RESP : rrt_pkg::S_FL_EMIT;
			end
			rrt_pkg::S_FL_EMIT: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_type  = rrt_pkg::REQ_RETX;
					res_blk   = cell_val[0];
					res_last  = emit_last;
					ctrl.op   = rrt_pkg::OP_SHIFT;
					ctrl.keep = 1'b1;
					ctrl.wpos = cnt_m1[IW-1:0];
					e_d       = e_q + CW'(1);
					if (emit_last) begin
						state_d = rrt_pkg::S_IDLE;
					end
				end
			end
			rrt_pkg::S_RS_SHIFT: begin
				ctrl.op = rrt_pkg::OP_SHIFT;
				n_d     = n_q - CW'(1);
				if (n_q == CW'(1)) begin
					state_d = rrt_pkg::S_RS_DONE;
				end
			end
			rrt_pkg::S_RS_DONE: begin
				if (out_free) begin
					res_load    = 1'b1;
					res_type    = rrt_pkg::REQ_RESTART;
					res_blk     = first_q;
					res_end     = cell_val[0];
					res_pending = '0;
					count_d     = '0;
					state_d     = rrt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rrt_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrt_pkg::S_CLEAR;
			sorted_q    <= 1'b1;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_we) begin
				sorted_q <= cfg_wdata;
			end
			if (state_q == rrt_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and sequencing registers
	always_ff @(posedge clk) begin
		if ((state_q == rrt_pkg::S_IDLE) && in_valid) begin
			kind_q <= kind;
			blk_q  <= block;
		end
		n_q     <= n_d;
		len_q   <= len_d;
		e_q     <= e_d;
		first_q <= first_d;
	end

	// result register, loaded on each result transfer
	always_ff @(posedge clk) begin
		if (res_load) begin
			type_q <= res_type;
			rblk_q <= res_blk;
			rend_q <= res_end;
			stat_q <= res_status;
			pend_q <= res_pending;
			last_q <= res_last;
		end
	end

	assign in_stall      = in_stall_c;
	assign out_valid     = out_valid_q;
	assign req_code      = type_q;
	assign req_block     = rblk_q;
	assign restart_end   = rend_q;
	assign status        = stat_q;
	assign pending_count = pend_q;
	assign last          = last_q;

	assign rs_out   = out_valid_q && (type_q == rrt_pkg::REQ_RESTART);
	assign flag_out = out_valid_q && (stat_q != rrt_pkg::STAT_OK);

`include "assert_macros.svh"

	`CHK_ALWAYS(a_count_range, count_q <= CW'(TD), "pending count beyond table depth")
	`CHK_IMPLY(a_clear_stall, state_q == rrt_pkg::S_CLEAR, in_stall, "input taken during clear")
	`CHK_IMPLY(a_restart_empty, rs_out, (pend_q == '0) && last_q, "restart leaves entries")
	`CHK_IMPLY(a_status_none, flag_out, type_q == rrt_pkg::REQ_NONE, "status on a flush result")

endmodule
`default_nettype wire
